@@ rtl/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants, types and the star closure function of the glob matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int PatternMax = 32;
  localparam int PosW       = PatternMax + 1;
  localparam int LenW       = 6;
  localparam int CharsW     = 8 * PatternMax;
  localparam int RegW       = 64;
  localparam int AddrW      = 6;
  localparam int IdxW       = 3;
  localparam int CloseSteps = $clog2(PosW);

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChSlash = 8'h2F;

  // register indexes
  localparam logic [IdxW-1:0] RegCharsLo   = 3'd0;
  localparam logic [IdxW-1:0] RegCharsMid  = 3'd1;
  localparam logic [IdxW-1:0] RegCharsHigh = 3'd2;
  localparam logic [IdxW-1:0] RegCharsTop  = 3'd3;
  localparam logic [IdxW-1:0] RegLength    = 3'd4;

  localparam logic [PosW-1:0] PosReset = PosW'(1);

  typedef struct packed {
    logic [CharsW-1:0] chars;
    logic [LenW-1:0]   len;   // already saturated to PatternMax
  } cfg_t;

  // close a position set over stars: bit j is set when bit j-1 is set and
  // pattern byte j-1 is a star; done as a log-depth prefix
  function automatic logic [PosW-1:0] close_stars(logic [PosW-1:0] set,
                                                  logic [PosW-1:0] star);
    logic [PosW-1:0] g;
    logic [PosW-1:0] p;
    g = set;
    p = {star[PosW-2:0], 1'b0};
    for (int lvl = 0; lvl < CloseSteps; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    return g;
  endfunction

endpackage

@@ rtl/glob_wildcard_matcher_core.sv @@
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_core
// Streamed glob match of subject strings against a configured pattern.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        request    in_valid_i / in_ready_o   symbol_i, has_symbol_i, end_of_string_i
//  out       result     out_valid_o / out_ready_i matched_o
//  cfg       apb write  psel, penable, pwrite     paddr, pwdata, prdata
//
//  one character per cycle: a request is registered, then the live position
//  set is updated from the held request; an end-of-string request, once
//  taken, loads the registered result. reset leaves only position zero live.
//  a stalled result holds only requests that end a string; others keep flowing.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    symbol_i,
  input  logic                          has_symbol_i,
  input  logic                          end_of_string_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gwm_pkg::AddrW-1:0]     paddr,
  input  logic [gwm_pkg::RegW-1:0]      pwdata,
  output logic [gwm_pkg::RegW-1:0]      prdata,
  output logic                          pready
);

  gwm_pkg::cfg_t            cfg;
  logic                     req_valid_q;
  logic [7:0]               sym_q;
  logic                     has_q;
  logic                     eos_q;
  logic [gwm_pkg::PosW-1:0] live_q;
  logic [gwm_pkg::PosW-1:0] live_d;
  logic [gwm_pkg::PosW-1:0] next_set;
  logic                     match_now;
  logic                     req_fire;
  logic                     out_valid_q;
  logic                     matched_q;

  gwm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gwm_pos_update u_update (
    .cfg_i        (cfg),
    .live_i       (live_q),
    .symbol_i     (sym_q),
    .has_symbol_i (has_q),
    .next_o       (next_set),
    .matched_o    (match_now)
  );

  // only a string end needs room in the result register
  assign req_fire   = req_valid_q && (!eos_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || req_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sym_q <= symbol_i;
      has_q <= has_symbol_i;
      eos_q <= end_of_string_i;
    end
  end

  always_comb begin
    live_d = live_q;
    if (req_fire) begin
      live_d = eos_q ? gwm_pkg::PosReset : next_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= gwm_pkg::PosReset;
      out_valid_q <= 1'b0;
    end else begin
      live_q <= live_d;
      if (req_fire && eos_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && eos_q) begin
      matched_q <= match_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

@@ rtl/gwm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gwm_cfg_regs
// APB-style register file holding the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module gwm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gwm_pkg::AddrW-1:0]     paddr,
  input  logic [gwm_pkg::RegW-1:0]      pwdata,
  output logic [gwm_pkg::RegW-1:0]      prdata,
  output logic                          pready,
  output gwm_pkg::cfg_t                 cfg_o
);

  logic [gwm_pkg::RegW-1:0] chars_q [4];
  logic [gwm_pkg::LenW-1:0] len_q;
  logic [gwm_pkg::IdxW-1:0] idx;
  logic                     wr_en;

  assign idx    = paddr[gwm_pkg::AddrW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q[0] <= '0;
      chars_q[1] <= '0;
      chars_q[2] <= '0;
      chars_q[3] <= '0;
      len_q      <= '0;
    end else if (wr_en) begin
      case (idx)
        gwm_pkg::RegCharsLo:   chars_q[0] <= pwdata;
        gwm_pkg::RegCharsMid:  chars_q[1] <= pwdata;
        gwm_pkg::RegCharsHigh: chars_q[2] <= pwdata;
        gwm_pkg::RegCharsTop:  chars_q[3] <= pwdata;
        gwm_pkg::RegLength:    len_q      <= pwdata[gwm_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gwm_pkg::RegCharsLo:   prdata = chars_q[0];
      gwm_pkg::RegCharsMid:  prdata = chars_q[1];
      gwm_pkg::RegCharsHigh: prdata = chars_q[2];
      gwm_pkg::RegCharsTop:  prdata = chars_q[3];
      gwm_pkg::RegLength:    prdata = gwm_pkg::RegW'(len_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.chars = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};
  // lengths above capacity saturate
  assign cfg_o.len   = (len_q > gwm_pkg::LenW'(gwm_pkg::PatternMax))
                     ? gwm_pkg::LenW'(gwm_pkg::PatternMax) : len_q;

endmodule

@@ rtl/gwm_pos_update.sv @@
// ----------------------------------------------------------------------------
// gwm_pos_update
// Next live position set for one subject character, and the match flag.
// ----------------------------------------------------------------------------
module gwm_pos_update (
  input  gwm_pkg::cfg_t                 cfg_i,
  input  logic [gwm_pkg::PosW-1:0]      live_i,
  input  logic [7:0]                    symbol_i,
  input  logic                          has_symbol_i,
  output logic [gwm_pkg::PosW-1:0]      next_o,
  output logic                          matched_o
);

  logic [gwm_pkg::PosW-1:0] star_v;
  logic [gwm_pkg::PosW-1:0] step_v;
  logic [gwm_pkg::PosW-1:0] cur;
  logic [gwm_pkg::PosW-1:0] stay;
  logic [gwm_pkg::PosW-1:0] adv;
  logic [gwm_pkg::PosW-1:0] moved;
  logic                     not_slash;
  logic [7:0]               pbyte;
  logic                     in_len;

  assign not_slash = (symbol_i != gwm_pkg::ChSlash);

  // per-position decode of the pattern byte, limited to the used length
  always_comb begin
    star_v = '0;
    step_v = '0;
    for (int i = 0; i < gwm_pkg::PatternMax; i++) begin
      pbyte  = cfg_i.chars[8*i +: 8];
      in_len = (gwm_pkg::LenW'(i) < cfg_i.len);
      star_v[i] = in_len && (pbyte == gwm_pkg::ChStar);
      if (pbyte == gwm_pkg::ChQuery) begin
        step_v[i] = in_len && not_slash;
      end else begin
        step_v[i] = in_len && (pbyte != gwm_pkg::ChStar) && (pbyte == symbol_i);
      end
    end
  end

  always_comb begin
    cur   = gwm_pkg::close_stars(live_i, star_v);
    stay  = cur & star_v & {gwm_pkg::PosW{not_slash}};
    adv   = cur & step_v;
    moved = gwm_pkg::close_stars(stay | (adv << 1), star_v);
    next_o = has_symbol_i ? moved : cur;
  end

  assign matched_o = next_o[cfg_i.len];

endmodule
